// File: design/orb_pkg.sv
package orb_pkg;

	// fixed field widths
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned COUNT_W = 5;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_DUMP  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH
	} state_t;

	// one stored entry
	typedef struct packed {
		logic [DATA_W-1:0] handle;
		logic [DATA_W-1:0] width;
		logic [DATA_W-1:0] height;
	} entry_t;

	// one result
	typedef struct packed {
		logic [DATA_W-1:0]  handle;
		logic [DATA_W-1:0]  width;
		logic [DATA_W-1:0]  height;
		logic               valid_res;
		logic               evicted;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
		logic               last;
	} res_t;

endpackage

// File: design/orb_req_if.sv
interface orb_req_if;
	logic                         valid;
	logic                         ready;
	logic [orb_pkg::OP_W-1:0]     op;
	logic [orb_pkg::DATA_W-1:0]   in_handle;
	logic [orb_pkg::DATA_W-1:0]   in_width;
	logic [orb_pkg::DATA_W-1:0]   in_height;

	modport source (output valid, output op, output in_handle, output in_width,
		output in_height, input ready);
	modport sink (input valid, input op, input in_handle, input in_width,
		input in_height, output ready);
endinterface

// File: design/orb_rsp_if.sv
interface orb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [orb_pkg::DATA_W-1:0]    out_handle;
	logic [orb_pkg::DATA_W-1:0]    out_width;
	logic [orb_pkg::DATA_W-1:0]    out_height;
	logic                          valid_res;
	logic                          evicted;
	logic [orb_pkg::COUNT_W-1:0]   count;
	logic                          is_empty;
	logic                          is_full;
	logic                          last;

	modport source (output valid, output out_handle, output out_width,
		output out_height, output valid_res, output evicted, output count,
		output is_empty, output is_full, output last, input ready);
	modport sink (input valid, input out_handle, input out_width,
		input out_height, input valid_res, input evicted, input count,
		input is_empty, input is_full, input last, output ready);
endinterface

// File: design/overwriting_ring_buffer.sv
// Ring buffer of CAPACITY frame entries that overwrites the oldest entry when full.
// req channel: op plus one entry (handle, width, height); a transfer happens when
// valid and ready are both high. rsp channel: one result per transfer, several
// for a dump; last marks the final result of each request.
// Write stores the entry and reports an evicted handle when the buffer was full.
// Read pops the oldest entry, or returns valid_res low when empty. Dump walks all
// stored handles oldest first without changing state.
// Entries live in one synchronous memory of CAPACITY+1 slots with a registered read.
// Write and read pass from request transfer through the execute step into the
// output register; the next request is taken once the block is back in idle.
// A dump fetches and then executes each further entry in turn, as the memory read is registered.
// The result register frees the request side: a new request is taken while the
// last result still waits. If rsp stalls, the block holds in its execute step.
// Reset clears the head and tail pointers, count and output valid; memory contents
// need no clearing since only written slots ever reach a result.
module overwriting_ring_buffer #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	orb_req_if.sink   req,
	orb_rsp_if.source rsp
);

	localparam int unsigned DEPTH = CAPACITY + 1;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// wrap-around slot increment
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

	orb_pkg::entry_t  mem [DEPTH];
	orb_pkg::entry_t  rd_data_q;
	orb_pkg::state_t  state_q, state_d;
	orb_pkg::op_t     op_q;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] dump_idx_q, dump_idx_d;
	orb_pkg::res_t    res_q, res_d;
	logic             rsp_valid_q;
	logic             load_res;
	logic             req_xfer;
	logic             out_free;

	assign req.ready = (state_q == orb_pkg::ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// sequencer and pointer update
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		rd_ptr_d   = rd_ptr_q;
		dump_idx_d = dump_idx_q;
		load_res   = 1'b0;
		res_d      = '0;
		rd_addr    = (state_q == orb_pkg::ST_IDLE) ? head_q : rd_ptr_q;
		unique case (state_q)
			orb_pkg::ST_IDLE: begin
				if (req_xfer) begin
					rd_ptr_d   = head_q;
					dump_idx_d = '0;
					state_d    = orb_pkg::ST_EXEC;
				end
			end
			orb_pkg::ST_FETCH: begin
				state_d = orb_pkg::ST_EXEC;
			end
			orb_pkg::ST_EXEC: begin
				if (out_free) begin
					load_res   = 1'b1;
					res_d.last = 1'b1;
					state_d    = orb_pkg::ST_IDLE;
					case (op_q)
						orb_pkg::OP_WRITE: begin
							tail_d = next_slot(tail_q);
							if (cnt_q == CNT_W'(CAPACITY)) begin
								res_d.handle  = rd_data_q.handle;
								res_d.evicted = 1'b1;
								head_d        = next_slot(head_q);
							end else begin
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						orb_pkg::OP_READ: begin
							if (cnt_q != '0) begin
								res_d.handle    = rd_data_q.handle;
								res_d.width     = rd_data_q.width;
								res_d.height    = rd_data_q.height;
								res_d.valid_res = 1'b1;
								head_d          = next_slot(head_q);
								cnt_d           = cnt_q - CNT_W'(1);
							end
						end
						orb_pkg::OP_DUMP: begin
							if (cnt_q != '0) begin
								res_d.handle    = rd_data_q.handle;
								res_d.valid_res = 1'b1;
								if (dump_idx_q != cnt_q - CNT_W'(1)) begin
									res_d.last = 1'b0;
									rd_ptr_d   = next_slot(rd_ptr_q);
									dump_idx_d = dump_idx_q + CNT_W'(1);
									state_d    = orb_pkg::ST_FETCH;
								end
							end
						end
						default: begin
						end
					endcase
					res_d.count    = orb_pkg::COUNT_W'(cnt_d);
					res_d.is_empty = (cnt_d == '0);
					res_d.is_full  = (cnt_d == CNT_W'(CAPACITY));
				end
			end
			default: begin
				state_d = orb_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= orb_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			if (load_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		rd_ptr_q   <= rd_ptr_d;
		dump_idx_q <= dump_idx_d;
		if (req_xfer) begin
			op_q <= orb_pkg::op_t'(req.op);
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	// entry memory: write on a write request transfer, registered read
	always_ff @(posedge clk) begin
		if (req_xfer && (orb_pkg::op_t'(req.op) == orb_pkg::OP_WRITE)) begin
			mem[tail_q] <= '{handle: req.in_handle, width: req.in_width,
				height: req.in_height};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_handle = res_q.handle;
	assign rsp.out_width  = res_q.width;
	assign rsp.out_height = res_q.height;
	assign rsp.valid_res  = res_q.valid_res;
	assign rsp.evicted    = res_q.evicted;
	assign rsp.count      = res_q.count;
	assign rsp.is_empty   = res_q.is_empty;
	assign rsp.is_full    = res_q.is_full;
	assign rsp.last       = res_q.last;

endmodule

// File: tb/overwriting_ring_buffer_tb.sv
`timescale 1ns / 1ps

module overwriting_ring_buffer_tb;

	localparam int unsigned RING_CAP   = 16;
	localparam int unsigned RING_SLOTS = RING_CAP + 1;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS = 71;

	typedef struct {
		orb_pkg::op_t op;
		logic [31:0]  handle;
		logic [31:0]  width;
		logic [31:0]  height;
	} frame_req_t;

	logic clk;
	logic arst_n;

	orb_req_if req_bus ();
	orb_rsp_if rsp_bus ();

	overwriting_ring_buffer #(
		.CAPACITY(RING_CAP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	// pending requests and expected results
	frame_req_t     frame_req_q[$];
	orb_pkg::res_t  expected_rsp_q[$];
	frame_req_t     cur_req;
	orb_pkg::res_t  want_rsp;

	// mirror of the ring contents
	logic [31:0] ring_handle [RING_SLOTS];
	logic [31:0] ring_width  [RING_SLOTS];
	logic [31:0] ring_height [RING_SLOTS];
	int unsigned ring_head;
	int unsigned ring_tail;

	int unsigned queued_cnt;
	int unsigned accepted_cnt;
	int unsigned mismatch_cnt;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int unsigned ring_fill();
		return (ring_tail + RING_SLOTS - ring_head) % RING_SLOTS;
	endfunction

	// result built from the fill level after the operation
	function automatic orb_pkg::res_t ring_result(logic [31:0] h, logic [31:0] w,
			logic [31:0] ht, logic vld, logic ev, logic lst);
		orb_pkg::res_t r;
		int unsigned   n;
		n           = ring_fill();
		r.handle    = h;
		r.width     = w;
		r.height    = ht;
		r.valid_res = vld;
		r.evicted   = ev;
		r.count     = n[orb_pkg::COUNT_W-1:0];
		r.is_empty  = (n == 0);
		r.is_full   = (n == RING_CAP);
		r.last      = lst;
		return r;
	endfunction

	// apply one request to the mirror and queue the results it causes
	task automatic ring_apply(input frame_req_t r);
		int unsigned n;
		int unsigned slot;
		logic [31:0] ev_handle;
		logic        ev;
		case (r.op)
			orb_pkg::OP_WRITE: begin
				ev_handle = '0;
				ev        = 1'b0;
				if ((ring_tail + 1) % RING_SLOTS == ring_head) begin
					ev_handle = ring_handle[ring_head];
					ev        = 1'b1;
				end
				ring_handle[ring_tail] = r.handle;
				ring_width[ring_tail]  = r.width;
				ring_height[ring_tail] = r.height;
				ring_tail = (ring_tail + 1) % RING_SLOTS;
				if (ring_tail == ring_head)
					ring_head = (ring_head + 1) % RING_SLOTS;
				expected_rsp_q.push_back(ring_result(ev_handle, '0, '0, 1'b0, ev, 1'b1));
			end
			orb_pkg::OP_READ: begin
				if (ring_fill() == 0) begin
					expected_rsp_q.push_back(ring_result('0, '0, '0, 1'b0, 1'b0, 1'b1));
				end else begin
					slot      = ring_head;
					ring_head = (ring_head + 1) % RING_SLOTS;
					expected_rsp_q.push_back(ring_result(ring_handle[slot], ring_width[slot],
						ring_height[slot], 1'b1, 1'b0, 1'b1));
				end
			end
			orb_pkg::OP_DUMP: begin
				n = ring_fill();
				if (n == 0) begin
					expected_rsp_q.push_back(ring_result('0, '0, '0, 1'b0, 1'b0, 1'b1));
				end else begin
					for (int unsigned i = 0; i < n; i++) begin
						slot = (ring_head + i) % RING_SLOTS;
						expected_rsp_q.push_back(ring_result(ring_handle[slot], '0, '0,
							1'b1, 1'b0, (i + 1 == n)));
					end
				end
			end
			default: begin
				expected_rsp_q.push_back(ring_result('0, '0, '0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// random word that often hits the extremes
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_item(input orb_pkg::op_t op, input logic [31:0] h,
			input logic [31:0] w, input logic [31:0] ht);
		frame_req_t r;
		r.op     = op;
		r.handle = h;
		r.width  = w;
		r.height = ht;
		frame_req_q.push_back(r);
		queued_cnt++;
	endtask

	// random traffic alternating between filling and draining bursts
	task automatic queue_random_phase(input int unsigned num);
		int unsigned  pick;
		bit           fill_bias;
		orb_pkg::op_t op;
		fill_bias = 1'b1;
		for (int unsigned i = 0; i < num; i++) begin
			if (i % 16 == 15)
				fill_bias = ~fill_bias;
			pick = $urandom_range(0, 99);
			if (fill_bias)
				op = orb_pkg::op_t'((pick < 70) ? orb_pkg::OP_WRITE :
					(pick < 85) ? orb_pkg::OP_READ :
					(pick < 95) ? orb_pkg::OP_DUMP : orb_pkg::OP_NOP);
			else
				op = orb_pkg::op_t'((pick < 20) ? orb_pkg::OP_WRITE :
					(pick < 85) ? orb_pkg::OP_READ :
					(pick < 95) ? orb_pkg::OP_DUMP : orb_pkg::OP_NOP);
			queue_item(op, rand_word(), rand_word(), rand_word());
		end
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				ring_apply(cur_req);
				accepted_cnt++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (frame_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req = frame_req_q.pop_front();
					req_bus.valid     <= 1'b1;
					req_bus.op        <= cur_req.op;
					req_bus.in_handle <= cur_req.handle;
					req_bus.in_width  <= cur_req.width;
					req_bus.in_height <= cur_req.height;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result transfer with no expected result: handle %0h",
						rsp_bus.out_handle);
					mismatch_cnt++;
				end else begin
					want_rsp = expected_rsp_q.pop_front();
					check_field("out_handle", want_rsp.handle, rsp_bus.out_handle);
					check_field("out_width", want_rsp.width, rsp_bus.out_width);
					check_field("out_height", want_rsp.height, rsp_bus.out_height);
					check_field("valid_res", 32'(want_rsp.valid_res),
						32'(rsp_bus.valid_res));
					check_field("evicted", 32'(want_rsp.evicted), 32'(rsp_bus.evicted));
					check_field("count", 32'(want_rsp.count), 32'(rsp_bus.count));
					check_field("is_empty", 32'(want_rsp.is_empty), 32'(rsp_bus.is_empty));
					check_field("is_full", 32'(want_rsp.is_full), 32'(rsp_bus.is_full));
					check_field("last", 32'(want_rsp.last), 32'(rsp_bus.last));
				end
			end
			rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("overwriting_ring_buffer regression: fail");
				$finish;
			end
		end
	end

	// reset, stimulus phases and end of run
	initial begin
		req_bus.valid     = 1'b0;
		req_bus.op        = orb_pkg::OP_NOP;
		req_bus.in_handle = '0;
		req_bus.in_width  = '0;
		req_bus.in_height = '0;
		rsp_bus.ready     = 1'b0;
		arst_n            = 1'b0;
		ring_head         = 0;
		ring_tail         = 0;
		queued_cnt        = 0;
		accepted_cnt      = 0;
		mismatch_cnt      = 0;
		quiet_cycles      = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;

		// directed: empty cases, fill past capacity, dump and read at full
		queue_item(orb_pkg::OP_READ, '1, '1, '1);
		queue_item(orb_pkg::OP_DUMP, '0, '0, '0);
		queue_item(orb_pkg::OP_NOP, '1, '1, '1);
		for (int unsigned i = 0; i < RING_CAP + 1; i++) begin
			case (i % 3)
				0: queue_item(orb_pkg::OP_WRITE, i, '0, '0);
				1: queue_item(orb_pkg::OP_WRITE, '1, '1, '1);
				default: queue_item(orb_pkg::OP_WRITE, $urandom, $urandom, $urandom);
			endcase
		end
		queue_item(orb_pkg::OP_DUMP, '0, '0, '0);
		queue_item(orb_pkg::OP_NOP, '0, '0, '0);
		queue_item(orb_pkg::OP_READ, '0, '0, '0);
		queue_item(orb_pkg::OP_WRITE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_item(orb_pkg::OP_READ, '0, '0, '0);
		queue_random_phase(PHASE_ITEMS);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait_drained();

		// sender idling only
		send_idle_pct  = 49;
		recv_stall_pct = 0;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// receiver stalling only
		send_idle_pct  = 0;
		recv_stall_pct = 49;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// both sides
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("overwriting_ring_buffer regression: pass");
		else
			$display("overwriting_ring_buffer regression: fail");
		$finish;
	end

endmodule
